// ----- sv/sem_pkg.sv -----
`default_nettype none

package sem_pkg;

    // register indexes on the configuration port
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // reset values of the frame size registers
    localparam logic [10:0] IMAGE_WIDTH_RESET  = 11'd640;
    localparam logic [10:0] IMAGE_HEIGHT_RESET = 11'd480;

    // result saturation
    localparam logic [7:0] MAG_MAX = 8'd255;

    // controller to datapath
    typedef struct packed {
        logic capture;    // input transfer: latch payload, read line stores
        logic shift;      // shift window, write line stores, step input counters
        logic grad;       // kernels, result position, step output counters
        logic square;     // square both gradients
        logic sum;        // add squares, start root
        logic root_step;  // one bit of the square root
        logic load_out;   // fill output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic row_full;   // all rows of the frame are in
        logic primed;     // this pixel completes a window
        logic root_last;  // final root bit in progress
    } status_t;

endpackage

`default_nettype wire

// ----- sv/sem_ctrl.sv -----
`default_nettype none

module sem_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    input  wire               flush,
    input  wire               out_stall,
    input  sem_pkg::status_t  status,
    output sem_pkg::cmd_t     cmd,
    output logic              in_stall,
    output logic              out_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_GRAD,
        S_SQUARE,
        S_SUM,
        S_ROOT,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.capture   = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // items that do not fit the frame phase are dropped here
                    if (flush && status.row_full)
                        state_next = S_GRAD;
                    else if (!flush && !status.row_full)
                        state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift  = 1'b1;
                state_next = status.primed ? S_GRAD : S_IDLE;
            end
            S_GRAD:
            begin
                cmd.grad   = 1'b1;
                state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid: set on load, cleared by the downstream transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/sem_datapath.sv -----
`default_nettype none

module sem_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire               clk,
    input  wire               rst_n,
    input  sem_pkg::cmd_t     cmd,
    output sem_pkg::status_t  status,
    input  wire  [7:0]        pixel,
    input  wire               flush,
    input  wire               cfg_we,
    input  wire               cfg_index,
    input  wire  [10:0]       cfg_data,
    output logic [7:0]        edge_strength,
    output logic [9:0]        out_col,
    output logic [9:0]        out_row,
    output logic              frame_last
);

    localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    // configuration
    logic [10:0]   image_width_reg;
    logic [10:0]   image_height_reg;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    // counters
    logic [CW-1:0] in_col_reg;
    logic [HW-1:0] in_row_reg;
    logic [CW-1:0] out_col_cnt_reg;
    logic [RW-1:0] out_row_cnt_reg;

    // line stores and window
    logic [7:0]    upper_mem  [MAX_WIDTH];
    logic [7:0]    middle_mem [MAX_WIDTH];
    logic [7:0]    up_rd_reg;
    logic [7:0]    mid_rd_reg;
    logic [7:0]    pix_reg;
    logic          is_flush_reg;
    logic [7:0]    win_reg [3][3];

    // result path
    logic [9:0]    ax_reg;
    logic [9:0]    ay_reg;
    logic [19:0]   sqx_reg;
    logic [19:0]   sqy_reg;
    logic [15:0]   s_reg;
    logic          sat_reg;
    logic [7:0]    root_reg;
    logic [2:0]    bit_reg;
    logic [CW-1:0] em_col_reg;
    logic [RW-1:0] em_row_reg;
    logic          em_last_reg;

    logic          cfg_hit;
    logic          in_col_wrap;
    logic          out_col_wrap;
    logic          out_row_end;
    logic          border;
    logic          last_hit;
    logic signed [11:0] gx;
    logic signed [11:0] gy;
    logic [20:0]   sq_sum;
    logic [7:0]    root_try;
    logic [15:0]   root_sq;
    logic [31:0]   col_ext;
    logic [31:0]   row_ext;

    // clamp frame size to the supported range
    always_comb
    begin
        if (int'(image_width_reg) < 3)
            w_eff = WW'(3);
        else if (int'(image_width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(image_width_reg);
        if (int'(image_height_reg) < 3)
            h_eff = HW'(3);
        else if (int'(image_height_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(image_height_reg);
    end

    assign cfg_hit      = cfg_we;
    assign in_col_wrap  = (int'(in_col_reg) + 1) >= int'(w_eff);
    assign out_col_wrap = (int'(out_col_cnt_reg) + 1) >= int'(w_eff);
    assign out_row_end  = (int'(out_row_cnt_reg) + 1) >= int'(h_eff);
    assign last_hit     = is_flush_reg && out_row_end && out_col_wrap;
    assign border       = (out_row_cnt_reg == '0) || out_row_end ||
                          (out_col_cnt_reg == '0) || out_col_wrap;

    // status to the controller
    always_comb
    begin
        status.row_full  = in_row_reg >= h_eff;
        status.primed    = (int'(in_row_reg) >= 2) ||
                           ((int'(in_row_reg) == 1) && (in_col_reg != '0));
        status.root_last = (bit_reg == 3'd0);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= sem_pkg::IMAGE_WIDTH_RESET;
            image_height_reg <= sem_pkg::IMAGE_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sem_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                sem_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:                   image_width_reg  <= image_width_reg;
            endcase
        end
    end

    // input and output position counters; a config write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg      <= '0;
            in_row_reg      <= '0;
            out_col_cnt_reg <= '0;
            out_row_cnt_reg <= '0;
        end
        else if (cfg_hit)
        begin
            in_col_reg      <= '0;
            in_row_reg      <= '0;
            out_col_cnt_reg <= '0;
            out_row_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.shift)
            begin
                if (in_col_wrap)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + HW'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
            end
            if (cmd.grad)
            begin
                if (last_hit)
                begin
                    in_col_reg      <= '0;
                    in_row_reg      <= '0;
                    out_col_cnt_reg <= '0;
                    out_row_cnt_reg <= '0;
                end
                else if (out_col_wrap)
                begin
                    out_col_cnt_reg <= '0;
                    out_row_cnt_reg <= out_row_cnt_reg + RW'(1);
                end
                else
                begin
                    out_col_cnt_reg <= out_col_cnt_reg + CW'(1);
                end
            end
        end
    end

    // line stores: read on transfer, write back in the shift cycle
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            up_rd_reg    <= upper_mem[in_col_reg];
            mid_rd_reg   <= middle_mem[in_col_reg];
            pix_reg      <= pixel;
            is_flush_reg <= flush;
        end
        if (cmd.shift)
        begin
            upper_mem[in_col_reg]  <= mid_rd_reg;
            middle_mem[in_col_reg] <= pix_reg;
        end
    end

    // 3x3 window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else if (cfg_hit || (cmd.grad && last_hit))
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else if (cmd.shift)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= up_rd_reg;
            win_reg[1][2] <= mid_rd_reg;
            win_reg[2][2] <= pix_reg;
        end
    end

    // Sobel kernels
    always_comb
    begin
        gx = ($signed({4'd0, win_reg[0][2]}) + ($signed({4'd0, win_reg[1][2]}) <<< 1) +
              $signed({4'd0, win_reg[2][2]})) -
             ($signed({4'd0, win_reg[0][0]}) + ($signed({4'd0, win_reg[1][0]}) <<< 1) +
              $signed({4'd0, win_reg[2][0]}));
        gy = ($signed({4'd0, win_reg[2][0]}) + ($signed({4'd0, win_reg[2][1]}) <<< 1) +
              $signed({4'd0, win_reg[2][2]})) -
             ($signed({4'd0, win_reg[0][0]}) + ($signed({4'd0, win_reg[0][1]}) <<< 1) +
              $signed({4'd0, win_reg[0][2]}));
    end

    assign sq_sum   = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign root_try = root_reg | (8'd1 << bit_reg);
    assign root_sq  = root_try * root_try;

    // magnitude pipeline: abs, square, sum, bitwise root
    always_ff @(posedge clk)
    begin
        if (cmd.grad)
        begin
            // border positions run a zero gradient through the root
            if (border)
            begin
                ax_reg <= '0;
                ay_reg <= '0;
            end
            else
            begin
                ax_reg <= gx[11] ? 10'(-gx) : 10'(gx);
                ay_reg <= gy[11] ? 10'(-gy) : 10'(gy);
            end
            em_col_reg  <= out_col_cnt_reg;
            em_row_reg  <= out_row_cnt_reg;
            em_last_reg <= last_hit;
        end
        if (cmd.square)
        begin
            sqx_reg <= ax_reg * ax_reg;
            sqy_reg <= ay_reg * ay_reg;
        end
        if (cmd.sum)
        begin
            s_reg    <= sq_sum[15:0];
            sat_reg  <= (sq_sum[20:16] != '0);
            root_reg <= '0;
            bit_reg  <= 3'd7;
        end
        if (cmd.root_step)
        begin
            if (root_sq <= s_reg)
                root_reg <= root_try;
            bit_reg <= bit_reg - 3'd1;
        end
    end

    assign col_ext = 32'(em_col_reg);
    assign row_ext = 32'(em_row_reg);

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            edge_strength <= sat_reg ? sem_pkg::MAG_MAX : root_reg;
            out_col       <= col_ext[9:0];
            out_row       <= row_ext[9:0];
            frame_last    <= em_last_reg;
        end
    end

endmodule

`default_nettype wire

// ----- sv/sobel_edge_magnitude.sv -----
// Sobel 3x3 gradient magnitude, controller plus datapath.
// A window-completing pixel passes capture, shift, gradient, square, sum, root steps, load;
// a flush item skips the shift, a pixel completing no window ends after the shift, a dropped
// item after its capture. The square root is eight-step bitwise; one item is in flight at a
// time, so the next is taken once the last is done, later while a held result blocks output.
// Reset: asynchronous active-low; counters, window and output valid clear, size 640x480.
`default_nettype none

module sobel_edge_magnitude #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [7:0]  pixel,
    input  wire         flush,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [7:0]  edge_strength,
    output logic [9:0]  out_col,
    output logic [9:0]  out_row,
    output logic        frame_last,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire  [10:0] cfg_data
);

    sem_pkg::cmd_t    cmd;
    sem_pkg::status_t status;

    sem_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .flush     (flush),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    sem_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .pixel         (pixel),
        .flush         (flush),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .edge_strength (edge_strength),
        .out_col       (out_col),
        .out_row       (out_row),
        .frame_last    (frame_last)
    );

endmodule

`default_nettype wire
